/* rtl/dpas_pkg.sv */
// Shared types and constants for the data-processing ALU and shifter.
`default_nettype none
package dpas_pkg;

	// Datapath width of the ALU and the shifter
	localparam int DATA_WIDTH = 32;

	// Fixed widths of the instruction fields
	localparam int OPCODE_W  = 4;
	localparam int FIELD_W   = 12;
	localparam int AMT_W     = 8;
	localparam int IMM_W     = 8;
	localparam int REG_IDX_W = 4;

	// Data-processing opcodes
	typedef enum logic [OPCODE_W-1:0] {
		OP_AND = 4'd0,
		OP_EOR = 4'd1,
		OP_SUB = 4'd2,
		OP_RSB = 4'd3,
		OP_ADD = 4'd4,
		OP_TST = 4'd8,
		OP_TEQ = 4'd9,
		OP_CMP = 4'd10,
		OP_ORR = 4'd12,
		OP_MOV = 4'd13
	} opcode_t;

	// Shift kinds, as encoded in operand bits 6:5
	typedef enum logic [1:0] {
		SH_LSL = 2'd0,
		SH_LSR = 2'd1,
		SH_ASR = 2'd2,
		SH_ROR = 2'd3
	} shift_t;

endpackage
`default_nettype wire

/* rtl/dpas_operand2.sv */
// Second-operand generation: rotated immediate or barrel-shifted register.
`default_nettype none
module dpas_operand2 #(
	parameter int DATA_WIDTH = dpas_pkg::DATA_WIDTH
) (
	input  wire logic                          immediate_form,
	input  wire logic [dpas_pkg::FIELD_W-1:0]  operand_field,
	input  wire logic [DATA_WIDTH-1:0]         shifted_value,
	input  wire logic [dpas_pkg::AMT_W-1:0]    amount_register_byte,
	output logic      [DATA_WIDTH-1:0]         operand2,
	output logic                               shifter_carry
);
	import dpas_pkg::*;

	localparam int SH_W = $clog2(DATA_WIDTH);

	shift_t                kind;
	logic [DATA_WIDTH-1:0] val;
	logic [AMT_W-1:0]      amt;
	logic [SH_W-1:0]       lo;
	logic                  big;
	logic [DATA_WIDTH:0]   lsl_ext;
	logic [DATA_WIDTH:0]   lsr_ext;
	logic signed [DATA_WIDTH:0]   asr_ext;
	logic [2*DATA_WIDTH-1:0]      ror_dbl;

	// Source select: immediate is a ROR by twice the 4-bit count
	always_comb begin
		if (immediate_form) begin
			kind = SH_ROR;
			val  = {{(DATA_WIDTH-IMM_W){1'b0}}, operand_field[IMM_W-1:0]};
			amt  = {{(AMT_W-5){1'b0}}, operand_field[11:8], 1'b0};
		end else begin
			kind = shift_t'(operand_field[6:5]);
			val  = shifted_value;
			amt  = operand_field[4] ? amount_register_byte
				: {{(AMT_W-5){1'b0}}, operand_field[11:7]};
		end
	end

	assign lo  = amt[SH_W-1:0];
	assign big = (amt >= AMT_W'(DATA_WIDTH));

	// Shift with one extra bit to catch the last bit shifted out
	assign lsl_ext = {1'b0, val} << lo;
	assign lsr_ext = {val, 1'b0} >> lo;
	assign asr_ext = $signed({val, 1'b0}) >>> lo;
	assign ror_dbl = {val, val} >> lo;

	// Result and carry per shift kind; zero amount passes through, carry 0
	always_comb begin
		operand2      = val;
		shifter_carry = 1'b0;
		if (amt != '0) begin
			case (kind)
				SH_LSL: begin
					if (!big) begin
						operand2      = lsl_ext[DATA_WIDTH-1:0];
						shifter_carry = lsl_ext[DATA_WIDTH];
					end else begin
						operand2 = '0;
					end
				end
				SH_LSR: begin
					if (!big) begin
						operand2      = lsr_ext[DATA_WIDTH:1];
						shifter_carry = lsr_ext[0];
					end else begin
						operand2 = '0;
					end
				end
				SH_ASR: begin
					if (!big) begin
						operand2      = asr_ext[DATA_WIDTH:1];
						shifter_carry = asr_ext[0];
					end else begin
						operand2 = {DATA_WIDTH{val[DATA_WIDTH-1]}};
					end
				end
				default: begin
					// ROR uses the amount modulo the width
					if (lo != '0) begin
						operand2      = ror_dbl[DATA_WIDTH-1:0];
						shifter_carry = ror_dbl[DATA_WIDTH-1];
					end
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/data_processing_alu_shifter.sv */
// Top level: data-processing ALU with barrel shifter, two register stages.
`default_nettype none
// One instruction is taken on each clock edge where start is high; busy is
// always low, so a request can follow in every cycle. The request is
// registered, the shifter and ALU (one 33-bit adder) work between the input
// register and the result register, and the result appears from the result
// register with done high for exactly one cycle. The receiver cannot stall:
// it must take each result in the cycle that done marks it.
module data_processing_alu_shifter #(
	parameter int DATA_WIDTH = dpas_pkg::DATA_WIDTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [dpas_pkg::OPCODE_W-1:0]   opcode,
	input  wire logic                            immediate_form,
	input  wire logic                            set_flags,
	input  wire logic [dpas_pkg::FIELD_W-1:0]    operand_field,
	input  wire logic [DATA_WIDTH-1:0]           first_operand,
	input  wire logic [DATA_WIDTH-1:0]           shifted_value,
	input  wire logic [dpas_pkg::AMT_W-1:0]      amount_register_byte,
	input  wire logic [dpas_pkg::REG_IDX_W-1:0]  dest_register,
	output logic                                 done,
	output logic [DATA_WIDTH-1:0]                result_value,
	output logic                                 write_back,
	output logic [dpas_pkg::REG_IDX_W-1:0]       dest_register_out,
	output logic                                 flags_written,
	output logic                                 flag_negative,
	output logic                                 flag_zero,
	output logic                                 flag_carry
);
	import dpas_pkg::*;

	// Input stage
	logic                   valid_s1;
	logic [OPCODE_W-1:0]    opcode_s1;
	logic                   imm_s1;
	logic                   sflag_s1;
	logic [FIELD_W-1:0]     field_s1;
	logic [DATA_WIDTH-1:0]  rn_s1;
	logic [DATA_WIDTH-1:0]  rm_s1;
	logic [AMT_W-1:0]       rs_s1;
	logic [REG_IDX_W-1:0]   rd_s1;

	// Execute results
	logic [DATA_WIDTH-1:0]  op2;
	logic                   sh_carry;
	logic [DATA_WIDTH-1:0]  add_x;
	logic [DATA_WIDTH-1:0]  add_y;
	logic                   add_cin;
	logic [DATA_WIDTH:0]    sum;
	logic [DATA_WIDTH-1:0]  res;
	logic                   carry;
	logic                   wb;

	// Result stage
	logic                   valid_s2;
	logic [DATA_WIDTH-1:0]  res_s2;
	logic                   wb_s2;
	logic [REG_IDX_W-1:0]   rd_s2;
	logic                   sflag_s2;
	logic                   n_s2;
	logic                   z_s2;
	logic                   c_s2;

	assign busy = 1'b0;

	// Valid bits of both stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	// Capture the request
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			opcode_s1 <= opcode;
			imm_s1    <= immediate_form;
			sflag_s1  <= set_flags;
			field_s1  <= operand_field;
			rn_s1     <= first_operand;
			rm_s1     <= shifted_value;
			rs_s1     <= amount_register_byte;
			rd_s1     <= dest_register;
		end
	end

	dpas_operand2 #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_operand2 (
		.immediate_form       (imm_s1),
		.operand_field        (field_s1),
		.shifted_value        (rm_s1),
		.amount_register_byte (rs_s1),
		.operand2             (op2),
		.shifter_carry        (sh_carry)
	);

	// Shared adder operands: subtraction as x + ~y + 1, carry is not-borrow
	always_comb begin
		add_x   = rn_s1;
		add_y   = op2;
		add_cin = 1'b0;
		case (opcode_s1)
			OP_SUB, OP_CMP: begin
				add_y   = ~op2;
				add_cin = 1'b1;
			end
			OP_RSB: begin
				add_x   = op2;
				add_y   = ~rn_s1;
				add_cin = 1'b1;
			end
			default: ;
		endcase
	end

	assign sum = {1'b0, add_x} + {1'b0, add_y} + {{DATA_WIDTH{1'b0}}, add_cin};

	// Operation select
	always_comb begin
		res   = '0;
		carry = sh_carry;
		wb    = 1'b1;
		unique case (opcode_s1) inside
			OP_AND, OP_TST: res = rn_s1 & op2;
			OP_EOR, OP_TEQ: res = rn_s1 ^ op2;
			OP_SUB, OP_RSB, OP_ADD, OP_CMP: begin
				res   = sum[DATA_WIDTH-1:0];
				carry = sum[DATA_WIDTH];
			end
			OP_ORR: res = rn_s1 | op2;
			OP_MOV: res = op2;
			default: res = '0;
		endcase
		if (opcode_s1 == OP_TST || opcode_s1 == OP_TEQ || opcode_s1 == OP_CMP) begin
			wb = 1'b0;
		end
	end

	// Result register; flags are zero when not being set
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			res_s2   <= res;
			wb_s2    <= wb;
			rd_s2    <= rd_s1;
			sflag_s2 <= sflag_s1;
			n_s2     <= sflag_s1 && res[DATA_WIDTH-1];
			z_s2     <= sflag_s1 && (res == '0);
			c_s2     <= sflag_s1 && carry;
		end
	end

	assign done              = valid_s2;
	assign result_value      = res_s2;
	assign write_back        = wb_s2;
	assign dest_register_out = rd_s2;
	assign flags_written     = sflag_s2;
	assign flag_negative     = n_s2;
	assign flag_zero         = z_s2;
	assign flag_carry        = c_s2;

`ifndef NO_ASSERTIONS
	// Each result follows an accepted request through both register stages
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 2))
		else $error("result without a request two cycles earlier");

	// Flags stay clear when not being set
	a_flags_off: assert property (@(posedge clk) disable iff (!arst_n)
		done && !flags_written |-> !flag_negative && !flag_zero && !flag_carry)
		else $error("flags set while flag update is off");

	// N and Z agree with the result value
	a_nz: assert property (@(posedge clk) disable iff (!arst_n)
		done && flags_written |->
			(flag_zero == (result_value == '0)) &&
			(flag_negative == result_value[DATA_WIDTH-1]))
		else $error("N or Z does not match the result");

	// Compare forms never write back
	a_no_wb: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (opcode_s1 == OP_TST || opcode_s1 == OP_TEQ ||
			opcode_s1 == OP_CMP) |=> done && !write_back)
		else $error("compare form marked for write-back");
`endif

endmodule
`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for the data-processing ALU with barrel shifter.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import dpas_pkg::*;

	localparam int RESET_CYCLES  = 9;
	localparam int RANDOM_ITEMS  = 925;
	// Requests sent with no idle cycles in between
	localparam int QUIET_FIRST   = 300;
	localparam int QUIET_LAST    = 520;
	// Request counts at which the sender waits for all results to drain
	localparam int DRAIN_FIRST   = 120;
	localparam int DRAIN_SECOND  = 640;
	localparam int IDLE_PERCENT  = 29;
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		logic [OPCODE_W-1:0]   opcode;
		logic                  immediate_form;
		logic                  set_flags;
		logic [FIELD_W-1:0]    operand_field;
		logic [DATA_WIDTH-1:0] first_operand;
		logic [DATA_WIDTH-1:0] shifted_value;
		logic [AMT_W-1:0]      amount_register_byte;
		logic [REG_IDX_W-1:0]  dest_register;
	} alu_instr_t;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] value;
		logic                  write_back;
		logic [REG_IDX_W-1:0]  dest;
		logic                  flags_written;
		logic                  neg;
		logic                  zero;
		logic                  carry;
	} alu_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [OPCODE_W-1:0]   opcode = '0;
	logic                  immediate_form = 1'b0;
	logic                  set_flags = 1'b0;
	logic [FIELD_W-1:0]    operand_field = '0;
	logic [DATA_WIDTH-1:0] first_operand = '0;
	logic [DATA_WIDTH-1:0] shifted_value = '0;
	logic [AMT_W-1:0]      amount_register_byte = '0;
	logic [REG_IDX_W-1:0]  dest_register = '0;
	logic                  done;
	logic [DATA_WIDTH-1:0] result_value;
	logic                  write_back;
	logic [REG_IDX_W-1:0]  dest_register_out;
	logic                  flags_written;
	logic                  flag_negative;
	logic                  flag_zero;
	logic                  flag_carry;

	alu_instr_t  instr_q[$];
	alu_result_t result_q[$];
	alu_instr_t  cur_instr;
	alu_result_t oldest_result;
	int          sent_count = 0;
	int          mismatch_count = 0;
	bit          pause_now;

	data_processing_alu_shifter i_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.start               (start),
		.busy                (busy),
		.opcode              (opcode),
		.immediate_form      (immediate_form),
		.set_flags           (set_flags),
		.operand_field       (operand_field),
		.first_operand       (first_operand),
		.shifted_value       (shifted_value),
		.amount_register_byte(amount_register_byte),
		.dest_register       (dest_register),
		.done                (done),
		.result_value        (result_value),
		.write_back          (write_back),
		.dest_register_out   (dest_register_out),
		.flags_written       (flags_written),
		.flag_negative       (flag_negative),
		.flag_zero           (flag_zero),
		.flag_carry          (flag_carry)
	);

	always #2 clk = ~clk;

	// Barrel shifter: a zero amount, and an out-of-range LSL, LSR or ASR amount, give carry 0
	function automatic void barrel_shift(input shift_t kind, input logic [DATA_WIDTH-1:0] v,
			input int unsigned amt, output logic [DATA_WIDTH-1:0] r, output logic c);
		c = 1'b0;
		r = v;
		if (amt != 0) begin
			case (kind)
				SH_LSL: begin
					if (amt < DATA_WIDTH) begin
						c = v[DATA_WIDTH - amt];
						r = v << amt;
					end else begin
						r = '0;
					end
				end
				SH_LSR: begin
					if (amt < DATA_WIDTH) begin
						c = v[amt - 1];
						r = v >> amt;
					end else begin
						r = '0;
					end
				end
				SH_ASR: begin
					if (amt < DATA_WIDTH) begin
						c = v[amt - 1];
						r = $signed(v) >>> amt;
					end else begin
						r = {DATA_WIDTH{v[DATA_WIDTH-1]}};
					end
				end
				default: begin
					// rotate amounts wrap at the word width
					amt = amt % DATA_WIDTH;
					if (amt != 0) begin
						c = v[amt - 1];
						r = (v >> amt) | (v << (DATA_WIDTH - amt));
					end
				end
			endcase
		end
	endfunction

	// Expected outcome of one instruction
	function automatic alu_result_t exec_instr(input alu_instr_t rq);
		alu_result_t           rs;
		logic [DATA_WIDTH-1:0] op2;
		logic [DATA_WIDTH-1:0] res;
		logic [DATA_WIDTH:0]   sum;
		logic                  c;
		int unsigned           amt;
		shift_t                kind;
		logic [DATA_WIDTH-1:0] src;

		if (rq.immediate_form) begin
			kind = SH_ROR;
			src  = {{(DATA_WIDTH-IMM_W){1'b0}}, rq.operand_field[IMM_W-1:0]};
			amt  = 2 * rq.operand_field[11:8];
		end else begin
			kind = shift_t'(rq.operand_field[6:5]);
			src  = rq.shifted_value;
			amt  = rq.operand_field[4] ? rq.amount_register_byte
				: {3'b000, rq.operand_field[11:7]};
		end
		barrel_shift(kind, src, amt, op2, c);

		case (rq.opcode)
			OP_AND, OP_TST: res = rq.first_operand & op2;
			OP_EOR, OP_TEQ: res = rq.first_operand ^ op2;
			OP_SUB, OP_CMP: begin
				res = rq.first_operand - op2;
				c   = rq.first_operand >= op2;
			end
			OP_RSB: begin
				res = op2 - rq.first_operand;
				c   = op2 >= rq.first_operand;
			end
			OP_ADD: begin
				sum = {1'b0, rq.first_operand} + {1'b0, op2};
				res = sum[DATA_WIDTH-1:0];
				c   = sum[DATA_WIDTH];
			end
			OP_ORR: res = rq.first_operand | op2;
			OP_MOV: res = op2;
			// undefined codes: zero result, shifter carry kept
			default: res = '0;
		endcase

		rs.value         = res;
		rs.write_back    = !(rq.opcode == OP_TST || rq.opcode == OP_TEQ || rq.opcode == OP_CMP);
		rs.dest          = rq.dest_register;
		rs.flags_written = rq.set_flags;
		rs.neg           = rq.set_flags & res[DATA_WIDTH-1];
		rs.zero          = rq.set_flags & (res == '0);
		rs.carry         = rq.set_flags & c;
		return rs;
	endfunction

	function automatic alu_instr_t make_instr(input logic [OPCODE_W-1:0] op, input logic imm,
			input logic sf, input logic [FIELD_W-1:0] field, input logic [DATA_WIDTH-1:0] rn,
			input logic [DATA_WIDTH-1:0] rm, input logic [AMT_W-1:0] rs,
			input logic [REG_IDX_W-1:0] rd);
		alu_instr_t it;
		it.opcode               = op;
		it.immediate_form       = imm;
		it.set_flags            = sf;
		it.operand_field        = field;
		it.first_operand        = rn;
		it.shifted_value        = rm;
		it.amount_register_byte = rs;
		it.dest_register        = rd;
		return it;
	endfunction

	// Word with a bias toward the corner values
	function automatic logic [DATA_WIDTH-1:0] pick_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return {1'b1, {(DATA_WIDTH-1){1'b0}}};
			3: return {1'b0, {(DATA_WIDTH-1){1'b1}}};
			default: return $urandom;
		endcase
	endfunction

	function automatic alu_instr_t random_instr();
		alu_instr_t it;
		it.opcode         = OPCODE_W'($urandom_range(0, 15));
		it.immediate_form = ($urandom_range(0, 2) == 0);
		it.set_flags      = ($urandom_range(0, 3) != 0);
		it.operand_field  = FIELD_W'($urandom);
		it.first_operand  = pick_word();
		it.shifted_value  = pick_word();
		if ($urandom_range(0, 9) == 0)
			it.first_operand = it.shifted_value;
		// register amounts clustered around the word width
		case ($urandom_range(0, 3))
			0: it.amount_register_byte = AMT_W'($urandom_range(0, DATA_WIDTH));
			1: it.amount_register_byte = AMT_W'($urandom_range(DATA_WIDTH - 1, DATA_WIDTH + 1));
			default: it.amount_register_byte = AMT_W'($urandom);
		endcase
		it.dest_register = REG_IDX_W'($urandom);
		return it;
	endfunction

	task automatic report_mismatch(input string what, input logic [DATA_WIDTH-1:0] got,
			input logic [DATA_WIDTH-1:0] want);
		$display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
		mismatch_count++;
	endtask

	// Driver: presents one request at a time from the pending queue
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				result_q.push_back(exec_instr(cur_instr));
				sent_count++;
			end
			if (!start || !busy) begin
				pause_now = (sent_count == DRAIN_FIRST || sent_count == DRAIN_SECOND)
					&& result_q.size() != 0;
				if (!(sent_count >= QUIET_FIRST && sent_count <= QUIET_LAST)
						&& $urandom_range(0, 99) < IDLE_PERCENT)
					pause_now = 1'b1;
				if (instr_q.size() == 0 || pause_now) begin
					start <= 1'b0;
				end else begin
					cur_instr = instr_q.pop_front();
					opcode               <= cur_instr.opcode;
					immediate_form       <= cur_instr.immediate_form;
					set_flags            <= cur_instr.set_flags;
					operand_field        <= cur_instr.operand_field;
					first_operand        <= cur_instr.first_operand;
					shifted_value        <= cur_instr.shifted_value;
					amount_register_byte <= cur_instr.amount_register_byte;
					dest_register        <= cur_instr.dest_register;
					start                <= 1'b1;
				end
			end
		end
	end

	// Monitor: compares each strobed result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (result_q.size() == 0) begin
				report_mismatch("result with no request pending", result_value, '0);
			end else begin
				oldest_result = result_q.pop_front();
				if (result_value !== oldest_result.value)
					report_mismatch("result_value", result_value, oldest_result.value);
				if (write_back !== oldest_result.write_back)
					report_mismatch("write_back", write_back, oldest_result.write_back);
				if (dest_register_out !== oldest_result.dest)
					report_mismatch("dest_register_out", dest_register_out, oldest_result.dest);
				if (flags_written !== oldest_result.flags_written)
					report_mismatch("flags_written", flags_written, oldest_result.flags_written);
				if (flag_negative !== oldest_result.neg)
					report_mismatch("flag_negative", flag_negative, oldest_result.neg);
				if (flag_zero !== oldest_result.zero)
					report_mismatch("flag_zero", flag_zero, oldest_result.zero);
				if (flag_carry !== oldest_result.carry)
					report_mismatch("flag_carry", flag_carry, oldest_result.carry);
			end
		end
	end

	// Stimulus, reset and end of run
	initial begin
		logic [DATA_WIDTH-1:0] w;

		// every opcode, defined or not
		for (int op = 0; op < 16; op++)
			instr_q.push_back(make_instr(OPCODE_W'(op), 1'b0, 1'b1, FIELD_W'($urandom),
				pick_word(), pick_word(), AMT_W'($urandom_range(0, DATA_WIDTH)),
				REG_IDX_W'($urandom)));
		// immediate extremes: zero result, and all ones rotated by the largest count
		instr_q.push_back(make_instr(OP_MOV, 1'b1, 1'b1, '0, $urandom, $urandom, '0, '0));
		instr_q.push_back(make_instr(OP_MOV, 1'b1, 1'b1, '1, $urandom, $urandom, '0, '1));
		// zero shift amount with carry out of the adder
		instr_q.push_back(make_instr(OP_ADD, 1'b0, 1'b1, {5'd0, SH_LSL, 1'b0, 4'd0},
			'1, '1, '1, 4'd1));
		// register amounts at and beyond the word width
		instr_q.push_back(make_instr(OP_MOV, 1'b0, 1'b1, {4'd0, 1'b0, SH_LSL, 1'b1, 4'd0},
			$urandom, '1, AMT_W'(DATA_WIDTH), 4'd2));
		instr_q.push_back(make_instr(OP_MOV, 1'b0, 1'b1, {4'd0, 1'b0, SH_LSR, 1'b1, 4'd0},
			$urandom, '1, '1, 4'd3));
		instr_q.push_back(make_instr(OP_MOV, 1'b0, 1'b1, {4'd0, 1'b0, SH_ASR, 1'b1, 4'd0},
			$urandom, {1'b1, {(DATA_WIDTH-2){1'b0}}, 1'b1}, AMT_W'(DATA_WIDTH + 8), 4'd4));
		instr_q.push_back(make_instr(OP_MOV, 1'b0, 1'b1, {4'd0, 1'b0, SH_ROR, 1'b1, 4'd0},
			$urandom, $urandom, AMT_W'(DATA_WIDTH), 4'd5));
		// compare of equal values, then a reverse subtract that borrows
		w = $urandom;
		instr_q.push_back(make_instr(OP_CMP, 1'b0, 1'b1, {5'd0, SH_LSL, 1'b0, 4'd0},
			w, w, '0, 4'd6));
		instr_q.push_back(make_instr(OP_RSB, 1'b0, 1'b1, {5'd0, SH_LSL, 1'b0, 4'd0},
			'1, w >> 1, '0, 4'd7));
		// flags not requested although the add carries
		instr_q.push_back(make_instr(OP_ADD, 1'b0, 1'b0, {5'd0, SH_LSL, 1'b0, 4'd0},
			'1, '1, '0, '1));
		for (int i = 0; i < RANDOM_ITEMS; i++)
			instr_q.push_back(random_instr());

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (instr_q.size() != 0 || start)
			@(posedge clk);
		while (result_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("** data_processing_alu_shifter: PASSED **");
		else
			$display("** data_processing_alu_shifter: FAILED **");
		$finish;
	end

	// Run limit, far beyond the slowest correct run
	initial begin
		#200000;
		$display("timeout with %0d results outstanding", result_q.size());
		$display("** data_processing_alu_shifter: FAILED **");
		$finish;
	end

endmodule
